FILE: src/tbsf_pkg.sv
// ----------------------------------------------------------------------------
// tbsf_pkg
// Shared constants, codes, types and helpers of the torus box-sum filter.
// ----------------------------------------------------------------------------
package tbsf_pkg;

  // Grid geometry
  localparam int WIDTH_LOG2  = 6;
  localparam int HEIGHT_LOG2 = 6;
  localparam int ADDR_W      = WIDTH_LOG2 + HEIGHT_LOG2;
  localparam int GRID_W      = 1 << WIDTH_LOG2;
  localparam int GRID_H      = 1 << HEIGHT_LOG2;
  localparam int W_MASK      = GRID_W - 1;
  localparam int H_MASK      = GRID_H - 1;
  localparam int POS_W       = (WIDTH_LOG2 > HEIGHT_LOG2) ? WIDTH_LOG2 : HEIGHT_LOG2;
  localparam int MIN_LOG2    = (WIDTH_LOG2 < HEIGHT_LOG2) ? WIDTH_LOG2 : HEIGHT_LOG2;
  localparam int RADIUS_LIM  = (1 << (MIN_LOG2 - 1)) - 1;

  // Payload widths
  localparam int DATA_W = 16;
  localparam int IDX_W  = 12;
  localparam int RAD_W  = 5;
  localparam int K_W    = RAD_W + 1;

  // Configuration port
  localparam int PDATA_W   = 32;
  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_RADIUS = '0;
  localparam logic [RAD_W-1:0]     RADIUS_RESET      = 5'd4;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic             start;
    logic             col;
    logic [RAD_W-1:0] radius;
  } pass_ctl_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } pass_rd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } pass_wr_t;

  // Raster address of a point on a line: rows in the row pass, columns in the
  // column pass.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic col,
                                                  input logic [POS_W-1:0] line,
                                                  input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    x = col ? line : pos;
    y = col ? pos : line;
    return (ADDR_W'(y & POS_W'(H_MASK)) << WIDTH_LOG2) | ADDR_W'(x & POS_W'(W_MASK));
  endfunction

endpackage

FILE: src/tbsf_if.sv
// ----------------------------------------------------------------------------
// tbsf_in_if / tbsf_out_if
// Valid/ready channels for command items and window-sum results.
// ----------------------------------------------------------------------------
interface tbsf_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [tbsf_pkg::IDX_W-1:0]  cell_index;
  logic [tbsf_pkg::DATA_W-1:0] cell_value;

  modport source (output valid, cmd, cell_index, cell_value, input ready);
  modport sink   (input valid, cmd, cell_index, cell_value, output ready);
endinterface

interface tbsf_out_if;
  logic                       valid;
  logic                       ready;
  logic [tbsf_pkg::DATA_W-1:0] window_sum;

  modport source (output valid, window_sum, input ready);
  modport sink   (input valid, window_sum, output ready);
endinterface

FILE: src/torus_box_sum_filter.sv
// ----------------------------------------------------------------------------
// torus_box_sum_filter
// Box-sum filter over a wrapping 64 x 64 grid of 16-bit cells.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_i. A write item (cmd 0) stores cell_value at
// cell_index; writes can stream at one per cycle while idle. A read
// item (cmd 1) returns, on out_o, the 16-bit wrapped sum of the square
// window of side 2r+1 around the cell, r being window_radius clamped to 31.
// Any write or radius change marks the sums stale. The next read then runs
// a row pass and a column pass through one sliding-sum engine, then reads the
// stored sum and loads it into the output register, as a read with fresh sums
// does at once; in_i stays low from a read transfer until its sum is in the
// output register.
// A result waits in the output register while out_o is stalled; the block
// keeps taking writes meanwhile, but a later read holds in its final step
// until the register frees up. Reset clears control state and sets the
// radius to 4 with sums stale; memory contents are not cleared. window_radius
// is at APB byte address 0; the user writes it only while idle (not enforced).
// ----------------------------------------------------------------------------
module torus_box_sum_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tbsf_in_if.sink                       in_i,
  tbsf_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tbsf_pkg::PADDR_W-1:0]  paddr,
  input  logic [tbsf_pkg::PDATA_W-1:0]  pwdata,
  output logic [tbsf_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {ST_IDLE, ST_ROW, ST_COL, ST_RD, ST_LOAD} state_e;

  state_e                      state_q;
  logic                        stale_q;
  logic [tbsf_pkg::RAD_W-1:0]  radius_q;
  logic [tbsf_pkg::ADDR_W-1:0] idx_q;
  logic                        start_q;
  logic                        start_d;
  logic                        col_q;
  logic                        out_valid_q;
  logic [tbsf_pkg::DATA_W-1:0] out_sum_q;

  logic                        in_xfer;
  logic                        cfg_wr;
  logic                        reg_hit;
  logic                        out_load;
  logic [tbsf_pkg::RAD_W-1:0]  eff_radius;
  logic [tbsf_pkg::ADDR_W-1:0] in_addr;

  tbsf_pkg::pass_ctl_t pass_ctl;
  tbsf_pkg::pass_rd_t  pass_rd;
  tbsf_pkg::pass_wr_t  pass_wr;
  logic                pass_done;

  logic [tbsf_pkg::DATA_W-1:0] grid_rdata_a;
  logic [tbsf_pkg::DATA_W-1:0] grid_rdata_b;
  logic [tbsf_pkg::DATA_W-1:0] row_rdata_a;
  logic [tbsf_pkg::DATA_W-1:0] row_rdata_b;
  logic [tbsf_pkg::DATA_W-1:0] win_rdata_q;
  logic [tbsf_pkg::DATA_W-1:0] win_mem [1 << tbsf_pkg::ADDR_W];

  assign in_xfer = in_i.valid & in_i.ready;
  assign in_addr = tbsf_pkg::ADDR_W'(in_i.cell_index);
  assign reg_hit = (paddr[tbsf_pkg::PADDR_W-1:2] == tbsf_pkg::REG_WINDOW_RADIUS);
  assign cfg_wr  = psel & penable & pwrite & reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? tbsf_pkg::PDATA_W'(radius_q) : '0;

  // Clamp so no cell is counted twice around the torus.
  assign eff_radius = (32'(radius_q) < tbsf_pkg::RADIUS_LIM)
                    ? radius_q : tbsf_pkg::RAD_W'(tbsf_pkg::RADIUS_LIM);

  // Kick the row pass on a stale read, the column pass once the row pass ends.
  assign start_d  = (in_xfer && (in_i.cmd == tbsf_pkg::CMD_READ) && stale_q)
                  || ((state_q == ST_ROW) && pass_done);
  assign out_load = (state_q == ST_LOAD) && (!out_valid_q || out_o.ready);

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.window_sum = out_sum_q;

  assign pass_ctl.start  = start_q;
  assign pass_ctl.col    = col_q;
  assign pass_ctl.radius = eff_radius;

  tbsf_pass u_pass (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (pass_ctl),
    .rd_o      (pass_rd),
    .rdata_a_i (col_q ? row_rdata_a : grid_rdata_a),
    .rdata_b_i (col_q ? row_rdata_b : grid_rdata_b),
    .wr_o      (pass_wr),
    .done_o    (pass_done)
  );

  tbsf_ram u_grid_ram (
    .clk_i     (clk_i),
    .we_i      (in_xfer && (in_i.cmd == tbsf_pkg::CMD_WRITE)),
    .waddr_i   (in_addr),
    .wdata_i   (in_i.cell_value),
    .raddr_a_i (pass_rd.addr_a),
    .raddr_b_i (pass_rd.addr_b),
    .rdata_a_o (grid_rdata_a),
    .rdata_b_o (grid_rdata_b)
  );

  tbsf_ram u_row_ram (
    .clk_i     (clk_i),
    .we_i      (pass_wr.en & ~col_q),
    .waddr_i   (pass_wr.addr),
    .wdata_i   (pass_wr.data),
    .raddr_a_i (pass_rd.addr_a),
    .raddr_b_i (pass_rd.addr_b),
    .rdata_a_o (row_rdata_a),
    .rdata_b_o (row_rdata_b)
  );

  // Window sums: filled by the column pass, read once per read item.
  always_ff @(posedge clk_i) begin
    if (pass_wr.en && col_q) begin
      win_mem[pass_wr.addr] <= pass_wr.data;
    end
    if (state_q == ST_RD) begin
      win_rdata_q <= win_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stale_q     <= 1'b1;
      radius_q    <= tbsf_pkg::RADIUS_RESET;
      idx_q       <= '0;
      start_q     <= 1'b0;
      col_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_sum_q   <= '0;
    end else begin
      start_q <= start_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        radius_q <= pwdata[tbsf_pkg::RAD_W-1:0];
      end
      if (cfg_wr || (in_xfer && (in_i.cmd == tbsf_pkg::CMD_WRITE))) begin
        stale_q <= 1'b1;
      end else if ((state_q == ST_COL) && pass_done) begin
        stale_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer && (in_i.cmd == tbsf_pkg::CMD_READ)) begin
            idx_q <= in_addr;
            if (stale_q) begin
              col_q   <= 1'b0;
              state_q <= ST_ROW;
            end else begin
              state_q <= ST_RD;
            end
          end
        end
        ST_ROW: begin
          if (pass_done) begin
            col_q   <= 1'b1;
            state_q <= ST_COL;
          end
        end
        ST_COL: begin
          if (pass_done) begin
            state_q <= ST_RD;
          end
        end
        ST_RD: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          // Hold until the output register is free.
          if (out_load) begin
            out_sum_q <= win_rdata_q;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/tbsf_ram.sv
// ----------------------------------------------------------------------------
// tbsf_ram
// Grid-sized memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module tbsf_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [tbsf_pkg::ADDR_W-1:0] waddr_i,
  input  logic [tbsf_pkg::DATA_W-1:0] wdata_i,
  input  logic [tbsf_pkg::ADDR_W-1:0] raddr_a_i,
  input  logic [tbsf_pkg::ADDR_W-1:0] raddr_b_i,
  output logic [tbsf_pkg::DATA_W-1:0] rdata_a_o,
  output logic [tbsf_pkg::DATA_W-1:0] rdata_b_o
);

  logic [tbsf_pkg::DATA_W-1:0] mem [1 << tbsf_pkg::ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

FILE: src/tbsf_pass.sv
// ----------------------------------------------------------------------------
// tbsf_pass
// Sliding-sum engine: one accumulator walks every line of the grid, first
// summing the 2r+1 cells around position zero, then adding the entering cell
// and dropping the leaving one per position. Runs the row pass and the column
// pass alike.
// ----------------------------------------------------------------------------
module tbsf_pass (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tbsf_pkg::pass_ctl_t         ctl_i,
  output tbsf_pkg::pass_rd_t          rd_o,
  input  logic [tbsf_pkg::DATA_W-1:0] rdata_a_i,
  input  logic [tbsf_pkg::DATA_W-1:0] rdata_b_i,
  output tbsf_pkg::pass_wr_t          wr_o,
  output logic                        done_o
);

  typedef enum logic [1:0] {S_IDLE, S_INIT, S_SLIDE} seq_e;

  seq_e                             seq_q;
  logic                             col_q;
  logic [tbsf_pkg::RAD_W-1:0]       radius_q;
  logic [tbsf_pkg::POS_W-1:0]       line_q;
  logic [tbsf_pkg::POS_W-1:0]       pos_q;
  logic [tbsf_pkg::K_W-1:0]         k_q;
  logic                             tag_valid_q;
  logic                             tag_slide_q;
  logic                             tag_first_q;
  logic                             tag_last_q;
  logic [tbsf_pkg::ADDR_W-1:0]      tag_dst_q;
  logic [tbsf_pkg::DATA_W-1:0]      acc_q;
  logic [tbsf_pkg::DATA_W-1:0]      acc_d;

  logic [tbsf_pkg::POS_W-1:0] pos_mask;
  logic [tbsf_pkg::POS_W-1:0] line_last;
  logic [tbsf_pkg::POS_W-1:0] r_p;
  logic [tbsf_pkg::POS_W-1:0] init_pos;
  logic [tbsf_pkg::POS_W-1:0] enter_pos;
  logic [tbsf_pkg::POS_W-1:0] leave_pos;
  logic                       k_last;
  logic                       pos_end;
  logic                       line_end;

  assign pos_mask  = col_q ? tbsf_pkg::POS_W'(tbsf_pkg::H_MASK)
                           : tbsf_pkg::POS_W'(tbsf_pkg::W_MASK);
  assign line_last = col_q ? tbsf_pkg::POS_W'(tbsf_pkg::W_MASK)
                           : tbsf_pkg::POS_W'(tbsf_pkg::H_MASK);
  assign r_p       = tbsf_pkg::POS_W'(radius_q);
  assign init_pos  = (tbsf_pkg::POS_W'(k_q) - r_p) & pos_mask;
  assign enter_pos = (pos_q + r_p + tbsf_pkg::POS_W'(1)) & pos_mask;
  assign leave_pos = (pos_q - r_p) & pos_mask;
  assign k_last    = (k_q == {radius_q, 1'b0});
  assign pos_end   = (pos_q == pos_mask);
  assign line_end  = (line_q == line_last);

  always_comb begin
    rd_o.addr_a = tbsf_pkg::cell_addr(col_q, line_q, enter_pos);
    rd_o.addr_b = tbsf_pkg::cell_addr(col_q, line_q, leave_pos);
    if (seq_q == S_INIT) begin
      rd_o.addr_a = tbsf_pkg::cell_addr(col_q, line_q, init_pos);
    end
  end

  // Window start for a line restarts from the first cell read.
  always_comb begin
    acc_d = acc_q;
    if (tag_valid_q) begin
      if (tag_slide_q) begin
        acc_d = acc_q + rdata_a_i - rdata_b_i;
      end else if (tag_first_q) begin
        acc_d = rdata_a_i;
      end else begin
        acc_d = acc_q + rdata_a_i;
      end
    end
  end

  assign wr_o.en   = tag_valid_q & tag_slide_q;
  assign wr_o.addr = tag_dst_q;
  assign wr_o.data = acc_q;
  assign done_o    = tag_valid_q & tag_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= S_IDLE;
      col_q       <= 1'b0;
      radius_q    <= '0;
      line_q      <= '0;
      pos_q       <= '0;
      k_q         <= '0;
      tag_valid_q <= 1'b0;
      tag_slide_q <= 1'b0;
      tag_first_q <= 1'b0;
      tag_last_q  <= 1'b0;
      tag_dst_q   <= '0;
      acc_q       <= '0;
    end else begin
      acc_q       <= acc_d;
      tag_valid_q <= (seq_q != S_IDLE);
      tag_slide_q <= (seq_q == S_SLIDE);
      tag_first_q <= (seq_q == S_INIT) && (k_q == '0);
      tag_last_q  <= (seq_q == S_SLIDE) && pos_end && line_end;
      tag_dst_q   <= tbsf_pkg::cell_addr(col_q, line_q, pos_q);
      case (seq_q)
        S_IDLE: begin
          if (ctl_i.start) begin
            col_q    <= ctl_i.col;
            radius_q <= ctl_i.radius;
            line_q   <= '0;
            pos_q    <= '0;
            k_q      <= '0;
            seq_q    <= S_INIT;
          end
        end
        S_INIT: begin
          if (k_last) begin
            pos_q <= '0;
            seq_q <= S_SLIDE;
          end else begin
            k_q <= k_q + tbsf_pkg::K_W'(1);
          end
        end
        S_SLIDE: begin
          if (pos_end) begin
            if (line_end) begin
              seq_q <= S_IDLE;
            end else begin
              line_q <= line_q + tbsf_pkg::POS_W'(1);
              k_q    <= '0;
              seq_q  <= S_INIT;
            end
          end else begin
            pos_q <= pos_q + tbsf_pkg::POS_W'(1);
          end
        end
        default: begin
          seq_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/tbsf_checker.sv
// ----------------------------------------------------------------------------
// tbsf_checker
// Port-level checks of the box-sum filter, bound to the top level.
// ----------------------------------------------------------------------------
module tbsf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         in_cmd_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [tbsf_pkg::DATA_W-1:0]  out_sum_i,
  input logic                         psel_i,
  input logic                         penable_i,
  input logic                         pwrite_i,
  input logic [tbsf_pkg::PADDR_W-1:0] paddr_i,
  input logic [tbsf_pkg::PDATA_W-1:0] pwdata_i,
  input logic [tbsf_pkg::PDATA_W-1:0] prdata_i
);

  logic in_xfer;
  logic radius_wr;

  assign in_xfer   = in_valid_i & in_ready_i;
  assign radius_wr = psel_i & penable_i & pwrite_i
                   & (paddr_i[tbsf_pkg::PADDR_W-1:2] == tbsf_pkg::REG_WINDOW_RADIUS);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sum_i))
    else $error("result dropped or changed while stalled");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_cmd_i == tbsf_pkg::CMD_READ) |=> !in_ready_i)
    else $error("ready right after a read transfer");

  a_write_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_cmd_i == tbsf_pkg::CMD_WRITE) |=> in_ready_i)
    else $error("write transfer stalled the input");

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared while input was open");

  a_radius_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    radius_wr |=> prdata_i[tbsf_pkg::RAD_W-1:0] == $past(pwdata_i[tbsf_pkg::RAD_W-1:0]))
    else $error("radius readback mismatch");

endmodule

bind torus_box_sum_filter tbsf_checker u_tbsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_cmd_i    (in_i.cmd),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_sum_i   (out_o.window_sum),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);

FILE: dv/box_sum_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_sum_checker
// Watches the command, result and register channels of the torus box-sum
// filter. Keeps a shadow grid and radius, works out the wrapped window sum
// for each read transfer, and compares every result transfer against the
// oldest pending sum.
// ----------------------------------------------------------------------------
module box_sum_checker
  import tbsf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  tbsf_in_if                  item_i,
  tbsf_out_if                 sum_i,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  input  logic [PDATA_W-1:0]  prdata,
  input  logic                pready,
  output int                  mismatch_count_o,
  output int                  sums_pending_o
);

  localparam int CELL_COUNT = GRID_W * GRID_H;

  logic [DATA_W-1:0] cell_store [CELL_COUNT];
  logic [DATA_W-1:0] pending_sums [$];
  logic [RAD_W-1:0]  radius;

  function automatic int clamped_radius();
    int side;
    int r;
    side = (GRID_W < GRID_H) ? GRID_W : GRID_H;
    r = int'(radius);
    if (r > (side - 1) / 2) r = (side - 1) / 2;
    return r;
  endfunction

  // Direct sum over the wrapped window; 16-bit accumulation matches the
  // modulo behavior of the sliding sums.
  function automatic logic [DATA_W-1:0] window_total(input logic [IDX_W-1:0] index);
    int r;
    int cy;
    int cx;
    int row;
    int col;
    logic [DATA_W-1:0] acc;
    r = clamped_radius();
    cy = (int'(index) >> WIDTH_LOG2) & H_MASK;
    cx = int'(index) & W_MASK;
    acc = '0;
    for (int dy = -r; dy <= r; dy++) begin
      row = (cy + dy) & H_MASK;
      for (int dx = -r; dx <= r; dx++) begin
        col = (cx + dx) & W_MASK;
        acc += cell_store[(row << WIDTH_LOG2) | col];
      end
    end
    return acc;
  endfunction

  task automatic report_mismatch(input string what, input logic [PDATA_W-1:0] got,
                                 input logic [PDATA_W-1:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i) begin
    logic [DATA_W-1:0] want;
    if (!rst_ni) begin
      radius = RADIUS_RESET;
      pending_sums.delete();
      sums_pending_o = 0;
    end else begin
      // retire the oldest sum before queuing a new one
      if (sum_i.valid && sum_i.ready) begin
        if (pending_sums.size() == 0) begin
          report_mismatch("window sum with no read outstanding",
                          PDATA_W'(sum_i.window_sum), '0);
        end else begin
          want = pending_sums.pop_front();
          if (sum_i.window_sum !== want)
            report_mismatch("window_sum", PDATA_W'(sum_i.window_sum), PDATA_W'(want));
        end
      end
      if (item_i.valid && item_i.ready) begin
        if (item_i.cmd == CMD_WRITE)
          cell_store[int'(item_i.cell_index) & (CELL_COUNT - 1)] = item_i.cell_value;
        else
          pending_sums = {pending_sums,
                          window_total(item_i.cell_index & IDX_W'(CELL_COUNT - 1))};
      end
      if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_WINDOW_RADIUS) begin
        if (pwrite)
          radius = pwdata[RAD_W-1:0];
        else if (prdata[RAD_W-1:0] !== radius)
          report_mismatch("window_radius readback", prdata, PDATA_W'(radius));
      end
      sums_pending_o = pending_sums.size();
    end
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the torus box-sum filter. Loads the whole grid,
// runs directed corner and radius cases, then random write bursts followed
// by read bursts or interleaved items over many radius settings, with random
// stalls on both channels. Prediction and comparison live in box_sum_checker.
// ----------------------------------------------------------------------------
module testbench;
  import tbsf_pkg::*;

  localparam int ITEM_TARGET   = 1900;
  localparam int STALL_LIMIT   = 100000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 1'b1;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int mismatch_count;
  int sums_pending;
  int write_count;
  int read_count;
  int radius_count;
  int idle_cycles;
  bit send_calm;

  tbsf_in_if  in_ch ();
  tbsf_out_if out_ch ();

  torus_box_sum_filter dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  box_sum_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .item_i           (in_ch),
    .sum_i            (out_ch),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .mismatch_count_o (mismatch_count),
    .sums_pending_o   (sums_pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short pauses, now and then a long one.
  function automatic int pause_len();
    if ($urandom_range(0, 19) != 0) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic int sender_gap();
    if (send_calm || $urandom_range(0, 99) < 55) return 0;
    return pause_len();
  endfunction

  function automatic int pick_radius();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 31;
      2, 3, 4, 5: return $urandom_range(1, 6);
      default: return $urandom_range(0, 31);
    endcase
  endfunction

  // Enter and leave at a falling edge; valid stays up so the next call can
  // replace the item without a bubble.
  task automatic send_item(input logic cmd, input int index, input logic [DATA_W-1:0] value);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.cmd        = cmd;
    in_ch.cell_index = IDX_W'(index);
    in_ch.cell_value = value;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (cmd == CMD_WRITE) write_count++;
    else read_count++;
  endtask

  task automatic write_cell(input int index, input logic [DATA_W-1:0] value);
    send_item(CMD_WRITE, index, value);
  endtask

  task automatic read_sum(input int index);
    send_item(CMD_READ, index, DATA_W'($urandom_range(0, 65535)));
  endtask

  // Hold off until every pending sum has come back and the block is quiet.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (sums_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_access(input logic is_write, input logic [REG_IDX_W-1:0] reg_idx,
                            input logic [PDATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = is_write;
    paddr   = PADDR_W'({reg_idx, 2'b00});
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_radius(input int r);
    settle();
    reg_access(1'b1, REG_WINDOW_RADIUS, ($urandom() & ~32'h1F) | PDATA_W'(r));
    radius_count++;
    if ($urandom_range(0, 1) == 0) reg_access(1'b0, REG_WINDOW_RADIUS, '0);
  endtask

  // Result side: random stalls, with calm stretches where ready stays high.
  initial begin
    int hold;
    int calm_left;
    bit calm;
    hold         = 0;
    calm_left    = 0;
    calm         = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(50, 400);
      end
      calm_left--;
      if (hold > 0) begin
        out_ch.ready = 1'b0;
        hold--;
      end else if (!calm && $urandom_range(0, 9) < 3) begin
        out_ch.ready = 1'b0;
        hold = pause_len() - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    int base;
    int kind;
    int n_write;
    int n_read;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_WRITE;
    in_ch.cell_index = '0;
    in_ch.cell_value = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    send_calm        = 1'b0;
    rst_n            = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    reg_access(1'b0, REG_WINDOW_RADIUS, '0);

    // Load every cell first: the sliding passes touch the whole grid.
    for (int i = 0; i < GRID_W * GRID_H; i++) begin
      case (i % 16)
        0:       write_cell(i, 16'hFFFF);
        1:       write_cell(i, 16'h0000);
        default: write_cell(i, DATA_W'($urandom_range(0, 65535)));
      endcase
    end

    // All four corners at the reset radius, windows wrap on all sides
    read_sum(0);
    read_sum(GRID_W * GRID_H - 1);
    read_sum(GRID_W - 1);
    read_sum((GRID_H - 1) * GRID_W);
    // Value extremes, each write makes the sums stale again
    write_cell(0, 16'hFFFF);
    write_cell(GRID_W * GRID_H - 1, 16'h0000);
    read_sum(0);
    read_sum(GRID_W * GRID_H - 1);
    // Radius zero: window is the cell itself
    set_radius(0);
    read_sum(2049);
    read_sum(0);
    // Largest radius
    set_radius(31);
    read_sum(0);
    read_sum(GRID_W * GRID_H - 1);
    // Write past the register list: radius must not move
    settle();
    reg_access(1'b1, REG_UNMAPPED, $urandom());
    reg_access(1'b0, REG_WINDOW_RADIUS, '0);
    read_sum(1000);
    // Write and read the same cell back to back
    set_radius(1);
    write_cell(100, 16'h8001);
    read_sum(100);
    write_cell(100, 16'h7FFE);
    read_sum(101);
    read_sum(7);

    base = write_count + read_count;
    while (write_count + read_count - base < ITEM_TARGET) begin
      send_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) set_radius(pick_radius());
      else if ($urandom_range(0, 5) == 0) settle();
      if ($urandom_range(0, 19) == 0) begin
        settle();
        reg_access(1'b1, REG_UNMAPPED, $urandom());
      end
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        // write burst, then reads against one set of fresh sums
        n_write = $urandom_range(1, 30);
        n_read  = $urandom_range(20, 60);
        repeat (n_write)
          write_cell($urandom_range(0, GRID_W * GRID_H - 1), DATA_W'($urandom_range(0, 65535)));
        repeat (n_read) read_sum($urandom_range(0, GRID_W * GRID_H - 1));
      end else begin
        // interleaved commands force repeated recomputation
        repeat ($urandom_range(3, 6)) begin
          if ($urandom_range(0, 1) == 0)
            write_cell($urandom_range(0, GRID_W * GRID_H - 1), DATA_W'($urandom_range(0, 65535)));
          else
            read_sum($urandom_range(0, GRID_W * GRID_H - 1));
        end
      end
    end

    in_ch.valid = 1'b0;
    while (sums_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d cell writes and %0d window reads over %0d radius settings,",
             write_count, read_count, radius_count);
    $display("with radius 0 and 31, wrapped corners and stalls on both channels.");
    if (mismatch_count == 0 && sums_pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches, %0d sums outstanding", mismatch_count, sums_pending);
      $display("testbench failed");
    end
    $finish;
  end

endmodule
